[src/i2crtm_pkg.sv]
// Shared types and constants for the I2C register transfer master.
`timescale 1ns / 1ps

package i2crtm_pkg;

    // Request codes carried in the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam int unsigned DELAY_W = 10;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_A    = 4'd1,
        PH_START_B    = 4'd2,
        PH_BIT_LOW    = 4'd3,
        PH_BIT_HIGH   = 4'd4,
        PH_ACK_LOW    = 4'd5,
        PH_ACK_HIGH   = 4'd6,
        PH_RSTART_LOW = 4'd7,
        PH_RD_LOW     = 4'd8,
        PH_RD_HIGH    = 4'd9,
        PH_MACK_LOW   = 4'd10,
        PH_MACK_HIGH  = 4'd11,
        PH_STOP_A     = 4'd12,
        PH_STOP_B     = 4'd13,
        PH_STOP_C     = 4'd14
    } t_phase;

    // Byte currently being shifted out
    typedef enum logic [1:0] {
        K_ADDR_W = 2'd0,
        K_REG    = 2'd1,
        K_DATA   = 2'd2,
        K_ADDR_R = 2'd3
    } t_kind;

    typedef struct packed {
        t_phase             phase;
        logic [2:0]         bit_index;
        logic [7:0]         shift_byte;
        logic [7:0]         bytes_left;
        logic [DELAY_W-1:0] delay_count;
        logic [6:0]         held_device;
        logic [7:0]         held_register;
        logic               is_read;
        t_kind              tx_kind;
        logic               nack_seen;
    } t_state;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       data_request;
        logic       read_valid;
        logic [7:0] read_data;
        logic       last_byte;
        logic       done_res;
        logic       nack_error;
    } t_out_item;

endpackage

[src/i2c_register_transfer_master.sv]
// I2C register transfer master: top level with input, state and result registers.
// An input item is held in the input register, then processed into the result register; a receiver stall holds it.
// One item per clock while the receiver does not stall; one input item is one bus tick and gives one result item.
// Bus timing lives in the sequencer state (delay_ticks input items per half bit phase).
// Reset (i_rst_n low, synchronous): bus idle, no result valid, delay_ticks = 1.
`timescale 1ns / 1ps

module i2c_register_transfer_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: delay_ticks
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [i2crtm_pkg::DELAY_W-1:0] i_cfg_data,
    // input items (one bus tick each)
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  i2crtm_pkg::t_in_item           i_in_item,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output i2crtm_pkg::t_out_item          o_out_item
);
    import i2crtm_pkg::*;

    logic [DELAY_W-1:0] r_delay_ticks;

    // input register stage
    logic      r_in_valid;
    t_in_item  r_in;

    // sequencer state, advanced once per processed item
    t_state    r_state;
    t_state    n_state;

    // result register stage
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic      fire;      // item in the input register is processed this cycle
    logic      in_take;

    // Processing runs whenever the result register is free or being drained.
    assign fire    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_in_valid && !fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    // delay_ticks only changes while no item waits in the input register
    assign o_cfg_ready = !r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= DELAY_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_delay_ticks <= i_cfg_data;
        end
    end

    i2crtm_step u_step (
        .i_state       (r_state),
        .i_item        (r_in),
        .i_delay_ticks (r_delay_ticks),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_IDLE, tx_kind: K_ADDR_W, default: '0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload flops
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // A finished transfer leaves the sequencer idle until the next result is written.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> (r_state.phase == PH_IDLE))
        else $error("done reported while sequencer not idle");

    // A received byte is always followed by the master acknowledge phase.
    a_read_mack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_valid) |-> (r_state.phase == PH_MACK_LOW))
        else $error("read byte reported outside acknowledge phase");

    // Error flag only comes with done, and an idle bus keeps both lines released.
    a_nack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.nack_error) |-> r_out.done_res)
        else $error("nack error without done");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |-> (r_out.scl_out && r_out.sda_out))
        else $error("lines driven while idle");

    // Processing a held item frees the input stage unless a new item arrives.
    a_in_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !in_take) |=> !r_in_valid)
        else $error("input stage not released after processing");

endmodule

[src/i2crtm_step.sv]
// Per-tick next-state and line/flag logic of the I2C transfer sequencer.
`timescale 1ns / 1ps

module i2crtm_step (
    input  i2crtm_pkg::t_state             i_state,
    input  i2crtm_pkg::t_in_item           i_item,
    input  logic [i2crtm_pkg::DELAY_W-1:0] i_delay_ticks,
    output i2crtm_pkg::t_state             o_state,
    output i2crtm_pkg::t_out_item          o_result
);
    import i2crtm_pkg::*;

    t_state             s;
    t_out_item          r;
    logic [DELAY_W-1:0] limit;

    always_comb begin
        s = i_state;
        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        limit = (i_delay_ticks == '0) ? DELAY_W'(1) : i_delay_ticks;

        // new request, only from idle
        if (s.phase == PH_IDLE && (i_item.mode == MODE_WRITE || i_item.mode == MODE_READ)) begin
            s.held_device   = i_item.dev_addr;
            s.held_register = i_item.reg_addr;
            s.bytes_left    = (i_item.byte_count == 8'd0) ? 8'd1 : i_item.byte_count;
            s.is_read       = (i_item.mode == MODE_READ);
            s.nack_seen     = 1'b0;
            s.tx_kind       = K_ADDR_W;
            s.shift_byte    = {i_item.dev_addr, 1'b0};
            s.bit_index     = 3'd0;
            s.delay_count   = '0;
            s.phase         = PH_START_A;
        end

        if (s.phase != PH_IDLE) begin
            r.busy_res = 1'b1;
            // line levels of the current phase
            case (s.phase)
                PH_START_B:    begin r.scl_out = 1'b1; r.sda_out = 1'b0; end
                PH_BIT_LOW:    begin r.scl_out = 1'b0; r.sda_out = s.shift_byte[7]; end
                PH_BIT_HIGH:   begin r.scl_out = 1'b1; r.sda_out = s.shift_byte[7]; end
                PH_ACK_LOW,
                PH_RSTART_LOW,
                PH_RD_LOW:     begin r.scl_out = 1'b0; r.sda_out = 1'b1; end
                PH_MACK_LOW:   begin
                    r.scl_out = 1'b0;
                    r.sda_out = (s.bytes_left == 8'd1);
                end
                PH_MACK_HIGH:  begin
                    r.scl_out = 1'b1;
                    r.sda_out = (s.bytes_left == 8'd1);
                end
                PH_STOP_A:     begin r.scl_out = 1'b0; r.sda_out = 1'b0; end
                PH_STOP_B:     begin r.scl_out = 1'b1; r.sda_out = 1'b0; end
                default:       begin r.scl_out = 1'b1; r.sda_out = 1'b1; end
            endcase

            if ({1'b0, s.delay_count} + (DELAY_W+1)'(1) < {1'b0, limit}) begin
                s.delay_count = s.delay_count + DELAY_W'(1);
            end else begin
                s.delay_count = '0;
                case (s.phase)
                    PH_START_A: s.phase = PH_START_B;
                    PH_START_B: begin
                        s.bit_index = 3'd0;
                        s.phase     = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: s.phase = PH_BIT_HIGH;
                    PH_BIT_HIGH: begin
                        if (s.bit_index == 3'd7) begin
                            s.phase = PH_ACK_LOW;
                        end else begin
                            s.bit_index  = s.bit_index + 3'd1;
                            s.shift_byte = {s.shift_byte[6:0], 1'b0};
                            s.phase      = PH_BIT_LOW;
                        end
                    end
                    PH_ACK_LOW: s.phase = PH_ACK_HIGH;
                    PH_ACK_HIGH: begin
                        s.bit_index = 3'd0;
                        if (i_item.sda_in) begin
                            // target did not acknowledge: abort with stop
                            s.nack_seen = 1'b1;
                            s.phase     = PH_STOP_A;
                        end else begin
                            case (s.tx_kind)
                                K_ADDR_W: begin
                                    s.tx_kind    = K_REG;
                                    s.shift_byte = s.held_register;
                                    s.phase      = PH_BIT_LOW;
                                end
                                K_REG: begin
                                    if (s.is_read) begin
                                        s.phase = PH_RSTART_LOW;
                                    end else begin
                                        s.tx_kind        = K_DATA;
                                        s.shift_byte     = i_item.write_data;
                                        r.data_request   = 1'b1;
                                        s.phase          = PH_BIT_LOW;
                                    end
                                end
                                K_DATA: begin
                                    s.bytes_left = s.bytes_left - 8'd1;
                                    if (s.bytes_left == 8'd0) begin
                                        s.phase = PH_STOP_A;
                                    end else begin
                                        s.shift_byte   = i_item.write_data;
                                        r.data_request = 1'b1;
                                        s.phase        = PH_BIT_LOW;
                                    end
                                end
                                default: begin
                                    s.shift_byte = 8'd0;
                                    s.phase      = PH_RD_LOW;
                                end
                            endcase
                        end
                    end
                    PH_RSTART_LOW: begin
                        s.tx_kind    = K_ADDR_R;
                        s.shift_byte = {s.held_device, 1'b1};
                        s.phase      = PH_START_A;
                    end
                    PH_RD_LOW: s.phase = PH_RD_HIGH;
                    PH_RD_HIGH: begin
                        s.shift_byte = {s.shift_byte[6:0], i_item.sda_in};
                        if (s.bit_index == 3'd7) begin
                            r.read_valid = 1'b1;
                            r.read_data  = s.shift_byte;
                            r.last_byte  = (s.bytes_left == 8'd1);
                            s.phase      = PH_MACK_LOW;
                        end else begin
                            s.bit_index = s.bit_index + 3'd1;
                            s.phase     = PH_RD_LOW;
                        end
                    end
                    PH_MACK_LOW: s.phase = PH_MACK_HIGH;
                    PH_MACK_HIGH: begin
                        s.bytes_left = s.bytes_left - 8'd1;
                        s.bit_index  = 3'd0;
                        s.shift_byte = 8'd0;
                        s.phase      = (s.bytes_left == 8'd0) ? PH_STOP_A : PH_RD_LOW;
                    end
                    PH_STOP_A: s.phase = PH_STOP_B;
                    PH_STOP_B: s.phase = PH_STOP_C;
                    default: begin
                        r.done_res   = 1'b1;
                        r.nack_error = s.nack_seen;
                        s.phase      = PH_IDLE;
                    end
                endcase
            end
        end

        o_state  = s;
        o_result = r;
    end

endmodule

[dv/i2c_register_transfer_master_checker.sv]
// Bus sequencer predictor and result scoreboard for the I2C register transfer master.
`timescale 1ns / 1ps

module i2c_register_transfer_master_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [i2crtm_pkg::DELAY_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  i2crtm_pkg::t_in_item           i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  i2crtm_pkg::t_out_item          i_out_item,
    output int                             o_fail_count,
    output int                             o_pending
);
    import i2crtm_pkg::*;

    localparam int SHOW_LIMIT = 10;

    // predicted sequencer state
    t_phase             ph;
    t_kind              kind;
    logic [2:0]         bidx;
    logic [7:0]         shreg;
    logic [7:0]         left;
    logic [DELAY_W-1:0] dcnt;
    logic [6:0]         dev;
    logic [7:0]         regb;
    logic               rd;
    logic               nack;
    logic [DELAY_W-1:0] delay_cfg;

    t_out_item bus_expect[$];

    function automatic string fmt(t_out_item r);
        return $sformatf({"scl=%0b sda=%0b busy=%0b dreq=%0b rvalid=%0b ",
                          "rdata=%02h last=%0b done=%0b nack=%0b"},
                         r.scl_out, r.sda_out, r.busy_res, r.data_request, r.read_valid,
                         r.read_data, r.last_byte, r.done_res, r.nack_error);
    endfunction

    // One bus tick: line levels of the current phase, then the end-of-phase step.
    task automatic bus_tick(input t_in_item it, output t_out_item r);
        logic [DELAY_W:0] lim;
        r   = '0;
        lim = (delay_cfg == '0) ? (DELAY_W+1)'(1) : {1'b0, delay_cfg};
        if (ph == PH_IDLE && (it.mode == MODE_WRITE || it.mode == MODE_READ)) begin
            dev   = it.dev_addr;
            regb  = it.reg_addr;
            left  = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
            rd    = (it.mode == MODE_READ);
            nack  = 1'b0;
            kind  = K_ADDR_W;
            shreg = {it.dev_addr, 1'b0};
            bidx  = '0;
            dcnt  = '0;
            ph    = PH_START_A;
        end
        if (ph == PH_IDLE) begin
            r.scl_out = 1'b1;
            r.sda_out = 1'b1;
        end else begin
            r.busy_res = 1'b1;
            case (ph)
                PH_START_A:    begin r.scl_out = 1'b1; r.sda_out = 1'b1;         end
                PH_START_B:    begin r.scl_out = 1'b1; r.sda_out = 1'b0;         end
                PH_BIT_LOW:    begin r.scl_out = 1'b0; r.sda_out = shreg[7];     end
                PH_BIT_HIGH:   begin r.scl_out = 1'b1; r.sda_out = shreg[7];     end
                PH_ACK_LOW:    begin r.scl_out = 1'b0; r.sda_out = 1'b1;         end
                PH_ACK_HIGH:   begin r.scl_out = 1'b1; r.sda_out = 1'b1;         end
                PH_RSTART_LOW: begin r.scl_out = 1'b0; r.sda_out = 1'b1;         end
                PH_RD_LOW:     begin r.scl_out = 1'b0; r.sda_out = 1'b1;         end
                PH_RD_HIGH:    begin r.scl_out = 1'b1; r.sda_out = 1'b1;         end
                PH_MACK_LOW:   begin r.scl_out = 1'b0; r.sda_out = (left == 8'd1); end
                PH_MACK_HIGH:  begin r.scl_out = 1'b1; r.sda_out = (left == 8'd1); end
                PH_STOP_A:     begin r.scl_out = 1'b0; r.sda_out = 1'b0;         end
                PH_STOP_B:     begin r.scl_out = 1'b1; r.sda_out = 1'b0;         end
                default:       begin r.scl_out = 1'b1; r.sda_out = 1'b1;         end
            endcase
            if ({1'b0, dcnt} + (DELAY_W+1)'(1) < lim) begin
                dcnt = dcnt + 1'b1;
            end else begin
                dcnt = '0;
                case (ph)
                    PH_START_A: ph = PH_START_B;
                    PH_START_B: begin
                        bidx = '0;
                        ph   = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: ph = PH_BIT_HIGH;
                    PH_BIT_HIGH: begin
                        if (bidx == 3'd7) begin
                            ph = PH_ACK_LOW;
                        end else begin
                            bidx  = bidx + 1'b1;
                            shreg = {shreg[6:0], 1'b0};
                            ph    = PH_BIT_LOW;
                        end
                    end
                    PH_ACK_LOW: ph = PH_ACK_HIGH;
                    PH_ACK_HIGH: begin
                        bidx = '0;
                        if (it.sda_in) begin
                            nack = 1'b1;
                            ph   = PH_STOP_A;
                        end else begin
                            case (kind)
                                K_ADDR_W: begin
                                    kind  = K_REG;
                                    shreg = regb;
                                    ph    = PH_BIT_LOW;
                                end
                                K_REG: begin
                                    if (rd) begin
                                        ph = PH_RSTART_LOW;
                                    end else begin
                                        kind           = K_DATA;
                                        shreg          = it.write_data;
                                        r.data_request = 1'b1;
                                        ph             = PH_BIT_LOW;
                                    end
                                end
                                K_DATA: begin
                                    left = left - 1'b1;
                                    if (left == 8'd0) begin
                                        ph = PH_STOP_A;
                                    end else begin
                                        shreg          = it.write_data;
                                        r.data_request = 1'b1;
                                        ph             = PH_BIT_LOW;
                                    end
                                end
                                default: begin
                                    shreg = '0;
                                    ph    = PH_RD_LOW;
                                end
                            endcase
                        end
                    end
                    PH_RSTART_LOW: begin
                        kind  = K_ADDR_R;
                        shreg = {dev, 1'b1};
                        ph    = PH_START_A;
                    end
                    PH_RD_LOW: ph = PH_RD_HIGH;
                    PH_RD_HIGH: begin
                        shreg = {shreg[6:0], it.sda_in};
                        if (bidx == 3'd7) begin
                            r.read_valid = 1'b1;
                            r.read_data  = shreg;
                            r.last_byte  = (left == 8'd1);
                            ph           = PH_MACK_LOW;
                        end else begin
                            bidx = bidx + 1'b1;
                            ph   = PH_RD_LOW;
                        end
                    end
                    PH_MACK_LOW: ph = PH_MACK_HIGH;
                    PH_MACK_HIGH: begin
                        left  = left - 1'b1;
                        bidx  = '0;
                        shreg = '0;
                        ph    = (left == 8'd0) ? PH_STOP_A : PH_RD_LOW;
                    end
                    PH_STOP_A: ph = PH_STOP_B;
                    PH_STOP_B: ph = PH_STOP_C;
                    default: begin
                        r.done_res   = 1'b1;
                        r.nack_error = nack;
                        ph           = PH_IDLE;
                    end
                endcase
            end
        end
    endtask

    // Sampled at the falling edge: every handshake seen here completes at the next rising edge.
    always @(negedge i_clk) begin
        t_out_item want;
        t_out_item res;
        if (!i_rst_n) begin
            ph           = PH_IDLE;
            kind         = K_ADDR_W;
            bidx         = '0;
            shreg        = '0;
            left         = '0;
            dcnt         = '0;
            dev          = '0;
            regb         = '0;
            rd           = 1'b0;
            nack         = 1'b0;
            delay_cfg    = DELAY_W'(1);
            o_fail_count = 0;
            bus_expect.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                delay_cfg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                bus_tick(i_in_item, res);
                bus_expect.push_back(res);
            end
            if (i_out_valid && !i_out_stall) begin
                if (bus_expect.size() == 0) begin
                    if (o_fail_count < SHOW_LIMIT)
                        $display("unexpected result item: %s", fmt(i_out_item));
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = bus_expect.pop_front();
                    if (i_out_item !== want) begin
                        if (o_fail_count < SHOW_LIMIT) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", fmt(want));
                            $display("  actual   %s", fmt(i_out_item));
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = bus_expect.size();
    end

endmodule

[dv/i2c_register_transfer_master_test.sv]
// Stimulus and verdict for the I2C register transfer master: bus ticks, acks, delays.
`timescale 1ns / 1ps

module i2c_register_transfer_master_test;
    import i2crtm_pkg::*;

    // Mode code the block treats as a plain tick
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int IDLE_PCT       = 22;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_LIMIT     = 8000;
    localparam int NO_NACK        = -1;
    localparam int NUM_PHASES     = 3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [DELAY_W-1:0] i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_item;

    int          fail_count;
    int          pending;
    int          stuck_cycles = 0;
    // no random idling on either side while set
    bit          calm = 1'b0;
    int unsigned req_sent = 0;
    int unsigned done_seen = 0;
    int unsigned ticks_sent = 0;
    int unsigned bus_delay = 1;

    // Random phase plan: delay setting and tick budget; one phase runs without idling
    int phase_delay  [NUM_PHASES] = '{0, 2, 1};
    int phase_budget [NUM_PHASES] = '{80, 60, 120};
    bit phase_calm   [NUM_PHASES] = '{0, 0, 1};

    i2c_register_transfer_master u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    i2c_register_transfer_master_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stall, off while calm is set.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Count finished transfers. Taken at the falling edge, ahead of the rising edge that
    // completes the handshake, so the stimulus process reads a settled value.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall && o_out_item.done_res)
            done_seen = done_seen + 1;
    end

    // Watchdog: cycles with no handshake on any channel.
    always @(negedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Plain tick with every field random; the spare mode code now and then.
    function automatic t_in_item idle_tick();
        t_in_item it;
        it.mode       = ($urandom_range(9) == 0) ? MODE_SPARE : MODE_TICK;
        it.dev_addr   = 7'($urandom_range(127));
        it.reg_addr   = 8'($urandom_range(255));
        it.byte_count = 8'($urandom_range(255));
        it.write_data = 8'($urandom_range(255));
        it.sda_in     = 1'($urandom_range(1));
        return it;
    endfunction

    // Present one item, with random gaps ahead of it, and hold it until taken.
    // Valid stays high on return; the caller's next drive decides what follows.
    task automatic send_item(input t_in_item it);
        logic took;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        ticks_sent = ticks_sent + 1;
        // a transfer that never finishes keeps asking for ticks
        if (ticks_sent >= ITEM_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] value);
        logic took;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
        bus_delay = 32'(value);
    endtask

    // Stop feeding, wait for every predicted result, then let the result register drain
    // with margin before touching the register.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register transfer, played tick by tick. The slave side is modeled by tick
    // position: with no NACK the bus layout is fixed in units of half bit phases, so the
    // ticks where the acknowledge is sampled (last tick of each ack-high phase) are known.
    // Those get ACK, or NACK on the chosen acknowledge; all other ticks carry random SDA,
    // which also becomes the read data. Runs until the transfer's done item comes back.
    task automatic run_transfer(input logic [1:0] mode, input logic [6:0] dev,
                                input logic [7:0] regb, input logic [7:0] cnt,
                                input int nack_at, input bit noisy);
        t_in_item it;
        int       d;
        int       n;
        int       t;
        int       slot;
        int       ack_no;
        int       last_ack;
        bit       aborted;
        d        = (bus_delay == 0) ? 1 : int'(bus_delay);
        n        = (cnt == 8'd0) ? 1 : int'(cnt);
        // ack-high slot of the final acknowledge driven by the slave
        last_ack = (mode == MODE_READ) ? 58 : 19 + 18 * (n + 1);
        last_ack = last_ack * d + d - 1;
        aborted  = 1'b0;

        it            = idle_tick();
        it.mode       = mode;
        it.dev_addr   = dev;
        it.reg_addr   = regb;
        it.byte_count = cnt;
        send_item(it);
        req_sent = req_sent + 1;
        t = 1;

        while (done_seen != req_sent) begin
            it     = idle_tick();
            slot   = t / d;
            ack_no = -1;
            if (!aborted && (t % d) == d - 1) begin
                // write: ack after every byte, 18 slots apart from slot 19;
                // read: address, register, then address+R after the repeated start
                if (mode == MODE_READ)
                    ack_no = (slot == 19) ? 0 : (slot == 37) ? 1 : (slot == 58) ? 2 : -1;
                else if (slot >= 19 && (slot - 19) % 18 == 0 && (slot - 19) / 18 <= n + 1)
                    ack_no = (slot - 19) / 18;
            end
            if (ack_no >= 0) begin
                it.sda_in = (ack_no == nack_at);
                aborted   = (ack_no == nack_at);
            end else if (noisy && !aborted && t < last_ack && $urandom_range(29) == 0) begin
                // request while busy: must be ignored
                it.mode = $urandom_range(1) ? MODE_READ : MODE_WRITE;
            end
            send_item(it);
            t = t + 1;
        end
    endtask

    // Random transfer: mostly short, some empty counts, occasional NACK.
    task automatic random_transfer();
        logic [1:0] mode;
        logic [7:0] cnt;
        int         roll;
        int         acks;
        int         nack_at;
        mode = $urandom_range(1) ? MODE_READ : MODE_WRITE;
        roll = int'($urandom_range(99));
        if (roll < 75)
            cnt = 8'($urandom_range(3, 1));
        else if (roll < 90)
            cnt = 8'($urandom_range(6, 4));
        else
            cnt = 8'd0;
        acks    = (mode == MODE_READ) ? 3 : ((cnt == 8'd0) ? 1 : int'(cnt)) + 2;
        nack_at = ($urandom_range(99) < 12) ? int'($urandom_range(acks - 1)) : NO_NACK;
        run_transfer(mode, 7'($urandom_range(127)), 8'($urandom_range(255)), cnt,
                     nack_at, 1'b1);
        repeat ($urandom_range(4)) send_item(idle_tick());
    endtask

    initial begin
        t_in_item    it;
        int unsigned start;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, shortest half phase ----
        write_delay(DELAY_W'(1));
        it      = idle_tick();
        it.mode = MODE_TICK;
        send_item(it);
        it.mode = MODE_SPARE;
        send_item(it);
        run_transfer(MODE_WRITE, 7'h7F, 8'hFF, 8'd2, NO_NACK, 1'b0);
        run_transfer(MODE_READ, 7'h00, 8'h00, 8'd2, NO_NACK, 1'b0);
        // byte count zero behaves as one
        run_transfer(MODE_READ, 7'h55, 8'hAA, 8'd0, NO_NACK, 1'b0);
        // NACK on the address byte and on address+R
        run_transfer(MODE_WRITE, 7'h11, 8'h22, 8'd2, 0, 1'b0);
        run_transfer(MODE_READ, 7'h70, 8'h0E, 8'd2, 2, 1'b0);

        // ---- random phases; delay zero acts as one ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_delay(DELAY_W'(phase_delay[p]));
            calm  = phase_calm[p];
            start = ticks_sent;
            while (ticks_sent - start < phase_budget[p])
                random_transfer();
            calm = 1'b0;
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
